@@ hw/rtl/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define CPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define CPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cpc_pkg.sv @@
// shared types, constants and helpers for the contrast pixel counter
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int PIX_W      = 8;
  localparam int COUNT_W    = 19;
  localparam int SIZE_W     = 10;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [SIZE_W-1:0] RST_LINE_WIDTH   = SIZE_W'(320);
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(200);
  localparam logic [THR_W-1:0]  RST_THRESHOLD    = THR_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_idx_e;

  // one line store entry: pending flag over the grey level
  typedef struct packed {
    logic             flag;
    logic [PIX_W-1:0] pix;
  } line_entry_t;

  // where an item sits in the frame
  typedef struct packed {
    logic first_col;
    logic first_row;
    logic last_col;
    logic bottom;
  } pos_flags_t;

  function automatic logic contrasts(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [THR_W-1:0] thr);
    logic [PIX_W-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff > thr;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cpc_line_store.sv @@
// previous-row line store, split into even and odd column banks
`timescale 1ns / 1ps
`default_nettype none

module cpc_line_store #(
  parameter int COL_W = $clog2(cpc_pkg::DEF_MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [COL_W-1:0]          rd_addr,
  output cpc_pkg::line_entry_t      rd_data,
  input  logic                      wr_a_en,
  input  logic [COL_W-1:0]          wr_a_addr,
  input  cpc_pkg::line_entry_t      wr_a_data,
  input  logic                      wr_b_en,
  input  logic [COL_W-1:0]          wr_b_addr,
  input  cpc_pkg::line_entry_t      wr_b_data
);
  import cpc_pkg::*;

  localparam int BANK_AW    = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  line_entry_t even_mem [BANK_DEPTH];
  line_entry_t odd_mem  [BANK_DEPTH];

  line_entry_t even_q;
  line_entry_t odd_q;
  logic        rd_odd;

  logic               even_we, odd_we;
  logic [BANK_AW-1:0] even_wa, odd_wa;
  line_entry_t        even_wd, odd_wd;
  logic [BANK_AW-1:0] rd_idx;

  // the two writes of one beat always hit different column parities
  always_comb begin
    even_we = 1'b0;
    odd_we  = 1'b0;
    even_wa = BANK_AW'(wr_a_addr >> 1);
    odd_wa  = BANK_AW'(wr_a_addr >> 1);
    even_wd = wr_a_data;
    odd_wd  = wr_a_data;
    if (wr_a_en) begin
      if (wr_a_addr[0]) odd_we = 1'b1;
      else              even_we = 1'b1;
    end
    if (wr_b_en) begin
      if (wr_b_addr[0]) begin
        odd_we = 1'b1;
        odd_wa = BANK_AW'(wr_b_addr >> 1);
        odd_wd = wr_b_data;
      end else begin
        even_we = 1'b1;
        even_wa = BANK_AW'(wr_b_addr >> 1);
        even_wd = wr_b_data;
      end
    end
  end

  assign rd_idx = BANK_AW'(rd_addr >> 1);

  always_ff @(posedge clk) begin
    if (even_we) even_mem[even_wa] <= even_wd;
    if (odd_we)  odd_mem[odd_wa]   <= odd_wd;
    if (rd_en) begin
      even_q <= even_mem[rd_idx];
      odd_q  <= odd_mem[rd_idx];
      rd_odd <= rd_addr[0];
    end
  end

  assign rd_data = rd_odd ? odd_q : even_q;

endmodule

`default_nettype wire

@@ hw/rtl/cpc_raster.sv @@
// raster position tracker: column, row and frame edge flags
`timescale 1ns / 1ps
`default_nettype none

module cpc_raster #(
  parameter int MAX_WIDTH  = cpc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cpc_pkg::DEF_MAX_HEIGHT,
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         frame_start,
  input  logic [cpc_pkg::SIZE_W-1:0]   line_width,
  input  logic [cpc_pkg::SIZE_W-1:0]   frame_height,
  output logic [COL_W-1:0]             col,
  output cpc_pkg::pos_flags_t          flags
);
  import cpc_pkg::*;

  localparam int CMP_CW = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
  localparam int CMP_RW = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;

  logic [COL_W-1:0] column_pos, column_pos_next;
  logic [ROW_W-1:0] row_pos, row_pos_next;
  logic [ROW_W-1:0] row;

  // a zero size acts as one by itself; the max-size clamp is the last index
  always_comb begin
    col = frame_start ? '0 : column_pos;
    row = frame_start ? '0 : row_pos;
    flags.first_col = (col == '0);
    flags.first_row = (row == '0);
    flags.last_col  = ((CMP_CW'(col) + CMP_CW'(1)) >= CMP_CW'(line_width)) ||
                      (col == COL_W'(MAX_WIDTH - 1));
    flags.bottom    = ((CMP_RW'(row) + CMP_RW'(1)) >= CMP_RW'(frame_height)) ||
                      (row == ROW_W'(MAX_HEIGHT - 1));
  end

  always_comb begin
    column_pos_next = col + COL_W'(1);
    row_pos_next    = row;
    if (flags.last_col) begin
      column_pos_next = '0;
      row_pos_next    = flags.bottom ? '0 : row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (advance) begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/contrast_pixel_counter.sv @@
// contrast pixel counter top level: config, tally stage and output register
//
//  channel  signals                              direction
//  in       in_valid/in_ready, pixel, frame_start      sink
//  out      out_valid/out_ready, contrast_count,       source
//           frame_done
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   sink
//
// one pixel per clock sustained while results are taken; an in beat passes the tally stage, then the output register
// the line store is split by column parity so the two write-backs of a beat
// (left neighbor and, at the row end, the pixel itself) go in the same cycle
// a read landing on an entry written by the beat ahead is forwarded
// synchronous reset clears position, tally and pipeline; no clearing pass
// in_ready drops only while a result waits and the tally stage is full
`timescale 1ns / 1ps
`default_nettype none

module contrast_pixel_counter #(
  parameter int MAX_WIDTH  = cpc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cpc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel beats
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cpc_pkg::PIX_W-1:0]         pixel,
  input  logic                              frame_start,
  // result beats
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cpc_pkg::COUNT_W-1:0]       contrast_count,
  output logic                              frame_done,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cpc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // configuration registers
  logic [SIZE_W-1:0] line_width;
  logic [SIZE_W-1:0] frame_height;
  logic [THR_W-1:0]  contrast_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width         <= RST_LINE_WIDTH;
      frame_height       <= RST_FRAME_HEIGHT;
      contrast_threshold <= RST_THRESHOLD;
    end else if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_LINE_WIDTH:   line_width         <= SIZE_W'(cfg_data);
        CFG_FRAME_HEIGHT: frame_height       <= SIZE_W'(cfg_data);
        CFG_THRESHOLD:    contrast_threshold <= THR_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // handshake control
  logic in_fire;
  logic s1_valid;
  logic s1_fire;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // position of the incoming beat
  logic [COL_W-1:0] rd_col;
  pos_flags_t       rd_flags;

  cpc_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_fire),
    .frame_start  (frame_start),
    .line_width   (line_width),
    .frame_height (frame_height),
    .col          (rd_col),
    .flags        (rd_flags)
  );

  // tally stage registers, loaded while the line store read is in flight
  logic [PIX_W-1:0] s1_pixel;
  logic             s1_frame_start;
  logic [COL_W-1:0] s1_col;
  pos_flags_t       s1_flags;
  logic             fwd_valid;
  line_entry_t      fwd_data;

  // running state
  logic [PIX_W-1:0]   left_pixel;
  logic               left_flag;
  logic [COUNT_W-1:0] pixel_tally;

  // line store ports
  line_entry_t      rd_data;
  logic             wr_a_en, wr_b_en;
  logic [COL_W-1:0] wr_a_addr, wr_b_addr;
  line_entry_t      wr_a_data, wr_b_data;

  cpc_line_store #(
    .COL_W (COL_W)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr   (rd_col),
    .rd_data   (rd_data),
    .wr_a_en   (wr_a_en),
    .wr_a_addr (wr_a_addr),
    .wr_a_data (wr_a_data),
    .wr_b_en   (wr_b_en),
    .wr_b_addr (wr_b_addr),
    .wr_b_data (wr_b_data)
  );

  // tally stage logic
  line_entry_t        above;
  logic               left_hit, up_hit, cur_flag, left_flag_upd, above_flag;
  logic [1:0]         tally_add;
  logic [COUNT_W-1:0] tally_next;

  always_comb begin
    above         = fwd_valid ? fwd_data : rd_data;
    left_hit      = !s1_flags.first_col &&
                    contrasts(s1_pixel, left_pixel, contrast_threshold);
    up_hit        = !s1_flags.first_row &&
                    contrasts(s1_pixel, above.pix, contrast_threshold);
    cur_flag      = left_hit || up_hit;
    left_flag_upd = left_flag || left_hit;
    // pixel above is final now
    above_flag    = !s1_flags.first_row && (above.flag || up_hit);

    tally_add = {1'b0, above_flag}
              + {1'b0, !s1_flags.first_col && s1_flags.bottom && left_flag_upd}
              + {1'b0, s1_flags.last_col && s1_flags.bottom && cur_flag};
    tally_next = (s1_frame_start ? '0 : pixel_tally) + COUNT_W'(tally_add);

    // left pixel has its right neighbor; row end pixel has none
    wr_a_en        = s1_fire && !s1_flags.first_col && !s1_flags.bottom;
    wr_a_addr      = s1_col - COL_W'(1);
    wr_a_data.flag = left_flag_upd;
    wr_a_data.pix  = left_pixel;
    wr_b_en        = s1_fire && s1_flags.last_col && !s1_flags.bottom;
    wr_b_addr      = s1_col;
    wr_b_data.flag = cur_flag;
    wr_b_data.pix  = s1_pixel;
  end

  // forward a write-back that lands on the entry being read this cycle
  logic        hit_a, hit_b;
  logic        fwd_valid_next;
  line_entry_t fwd_data_next;

  always_comb begin
    hit_a          = wr_a_en && (wr_a_addr == rd_col);
    hit_b          = wr_b_en && (wr_b_addr == rd_col);
    fwd_valid_next = hit_a || hit_b;
    fwd_data_next  = hit_a ? wr_a_data : wr_b_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel       <= pixel;
      s1_frame_start <= frame_start;
      s1_col         <= rd_col;
      s1_flags       <= rd_flags;
      fwd_data       <= fwd_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (in_fire) begin
      fwd_valid <= fwd_valid_next;
    end
  end

  // running state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel  <= '0;
      left_flag   <= 1'b0;
      pixel_tally <= '0;
      out_valid   <= 1'b0;
      frame_done  <= 1'b0;
    end else begin
      if (s1_fire) begin
        left_pixel  <= s1_pixel;
        left_flag   <= cur_flag;
        pixel_tally <= tally_next;
        frame_done  <= s1_flags.last_col && s1_flags.bottom;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  assign contrast_count = pixel_tally;

endmodule

`default_nettype wire

@@ hw/rtl/cpc_checker.sv @@
// port-level checks for the contrast pixel counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cpc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cpc_pkg::COUNT_W-1:0]   contrast_count,
  input logic                          frame_done,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // a stalled result beat keeps its payload
  `CPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(contrast_count) && $stable(frame_done), "result beat changed while stalled")

  // no result beat right after reset
  `CPC_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result beat right after reset")

  // input only backs up behind a stalled result
  `CPC_ASSERT(a_in_stall, !in_ready |-> out_valid && !out_ready, "input stalled without output back-pressure")

  // register writes never wait
  `CPC_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "register write stalled")

endmodule

bind contrast_pixel_counter cpc_checker u_cpc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .contrast_count (contrast_count),
  .frame_done     (frame_done),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for the contrast pixel counter: tally tracker, stimulus, result sink
`timescale 1ns / 1ps

module tb_top;
  import cpc_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int MAX_H        = DEF_MAX_HEIGHT;
  localparam int RANDOM_BEATS = 800;
  localparam int PRINT_LIMIT  = 40;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int CUT_LEN      = 200;
  // the one index that decodes to no register
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // what one result beat should carry
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               done;
  } tally_beat_t;

  // keeps its own copy of registers, line store and position, and predicts the
  // running contrast count for every pixel beat the block accepts
  class contrast_tally_tracker;
    logic [SIZE_W-1:0]  width_reg  = RST_LINE_WIDTH;
    logic [SIZE_W-1:0]  height_reg = RST_FRAME_HEIGHT;
    logic [THR_W-1:0]   thr_reg    = RST_THRESHOLD;
    line_entry_t        line_mem [MAX_W];
    int unsigned        col;
    int unsigned        row;
    logic [PIX_W-1:0]   left_pix   = '0;
    bit                 left_hit;
    logic [COUNT_W-1:0] tally      = '0;
    tally_beat_t        pending_tallies [$];
    int                 errors;
    int                 results_seen;
    int                 frames_done;

    task report(string what);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LINE_WIDTH:   width_reg  = data;
        CFG_FRAME_HEIGHT: height_reg = data;
        CFG_THRESHOLD:    thr_reg    = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clip_size(logic [SIZE_W-1:0] v, int unsigned cap);
      if (v == 0) return 1;
      return (v > cap) ? cap : v;
    endfunction

    function bit differs_enough(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      int abs_diff;
      abs_diff = int'(a) - int'(b);
      if (abs_diff < 0) abs_diff = -abs_diff;
      return abs_diff > int'(thr_reg);
    endfunction

    function int pending();
      return pending_tallies.size();
    endfunction

    function void predict_tally(logic [PIX_W-1:0] p, logic fs);
      int unsigned w, h, c, r;
      bit          last_col, bottom, hit, hit_above;
      line_entry_t above;
      w = clip_size(width_reg, MAX_W);
      h = clip_size(height_reg, MAX_H);
      if (fs) begin
        tally = '0;
        col   = 0;
        row   = 0;
      end
      c        = (col >= MAX_W) ? MAX_W - 1 : col;
      r        = row;
      last_col = (c + 1 >= w);
      bottom   = (r + 1 >= h);
      hit      = 1'b0;
      // left neighbor, both pixels learn of the contrast
      if (c > 0 && differs_enough(p, left_pix)) begin
        hit      = 1'b1;
        left_hit = 1'b1;
      end
      // pixel above is final now
      if (r > 0) begin
        above     = line_mem[c];
        hit_above = above.flag;
        if (differs_enough(p, above.pix)) begin
          hit       = 1'b1;
          hit_above = 1'b1;
        end
        tally += COUNT_W'(hit_above);
      end
      // left pixel has its right neighbor now
      if (c > 0) begin
        if (bottom) tally += COUNT_W'(left_hit);
        else line_mem[c - 1] = '{flag: left_hit, pix: left_pix};
      end
      // row end, nothing to the right
      if (last_col) begin
        if (bottom) tally += COUNT_W'(hit);
        else line_mem[c] = '{flag: hit, pix: p};
      end
      left_pix = p;
      left_hit = hit;
      if (last_col) begin
        col = 0;
        row = bottom ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
      pending_tallies.push_back('{count: tally, done: last_col && bottom});
    endfunction

    task check_result(logic [COUNT_W-1:0] got_count, logic got_done);
      tally_beat_t want;
      results_seen++;
      if (pending_tallies.size() == 0) begin
        report($sformatf("result %0d with no pixel outstanding", results_seen));
        return;
      end
      want = pending_tallies.pop_front();
      if (got_count !== want.count)
        report($sformatf("result %0d contrast_count %0d, predicted %0d",
                         results_seen, got_count, want.count));
      if (got_done !== want.done)
        report($sformatf("result %0d frame_done %b, predicted %b",
                         results_seen, got_done, want.done));
      if (got_done === 1'b1) frames_done++;
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel;
  logic                  frame_start;
  logic                  out_valid;
  logic                  out_ready;
  logic [COUNT_W-1:0]    contrast_count;
  logic                  frame_done;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  contrast_tally_tracker tracker;
  bit feed_paced;         // sender draws a gap before each beat
  bit sink_paced;         // receiver draws a stall before each beat
  int hold_off_cycles;    // long receiver stall, taken by the sink process
  int beats_sent;
  int settings_used;

  contrast_pixel_counter dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel          (pixel),
    .frame_start    (frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .contrast_count (contrast_count),
    .frame_done     (frame_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // one pixel beat, inputs move on the falling edge, acceptance seen on the rising one
  // valid stays up between back-to-back beats
  task automatic send_pixel(input logic [PIX_W-1:0] p, input logic fs);
    int gap;
    gap = feed_paced ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid    = 1'b1;
    pixel       = p;
    frame_start = fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.predict_tally(p, fs);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // block is idle once every predicted result has come back
  // (every pixel beat makes exactly one result)
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] thr_word);
    settle();
    write_reg(CFG_LINE_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_THRESHOLD, thr_word);
    settings_used++;
  endtask

  // result sink: random stalls per beat, plus the long hold-off when asked
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_off_cycles > 0) begin
        repeat (hold_off_cycles) begin
          @(negedge clk);
          out_ready = 1'b0;
        end
        hold_off_cycles = 0;
      end
      stall = sink_paced ? $urandom_range(0, 4) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_result(contrast_count, frame_done);
    end
  end

  initial begin : stimulus
    logic [PIX_W-1:0]      frame_a [9];
    logic [SIZE_W-1:0]     w_word, h_word;
    logic [CFG_DATA_W-1:0] thr_word;
    logic [PIX_W-1:0]      pix, last_pix;
    int unsigned           w_eff, h_eff, full, len, r, c;
    int                    rand_goal, phase_no, frames, v, delta, drain_wait;
    bit                    cut, prev_cut, fs_first;

    frame_a         = '{8'd0, 8'd0, 8'd255,
                        8'd0, 8'd255, 8'd255,
                        8'd255, 8'd0, 8'd0};
    tracker         = new;
    rst             = 1'b1;
    in_valid        = 1'b0;
    pixel           = '0;
    frame_start     = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_LINE_WIDTH;
    cfg_data        = '0;
    feed_paced      = 1'b1;
    sink_paced      = 1'b1;
    hold_off_cycles = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // ---- directed part ----
    // 3x3 frame at threshold zero: any step contrasts, equal neighbors do not
    configure(10'd3, 10'd3, 10'd0);
    // unmapped index must leave every register alone
    write_reg(CFG_NO_REG, '1);
    for (int k = 0; k < 9; k++) send_pixel(frame_a[k], k == 0);
    // no frame_start: position wraps, count keeps adding
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    // frame_start mid-frame drops what was pending
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);

    // width zero acts as one, height past the cap, threshold at max with
    // the upper data bits set: nothing ever contrasts
    configure(10'd0, 10'd1023, 10'h3FF);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);

    // shrink both sizes mid-frame: column 2 of row 1 becomes the last pixel
    configure(10'd4, 10'd4, 10'd100);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    settle();
    write_reg(CFG_LINE_WIDTH, 10'd2);
    write_reg(CFG_FRAME_HEIGHT, 10'd2);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd200, 1'b0);

    // ---- random part ----
    // each setting runs one to three frames; big frames get cut short and
    // the next one restarts with frame_start
    rand_goal = beats_sent + RANDOM_BEATS;
    phase_no  = 0;
    last_pix  = '0;
    while (beats_sent < rand_goal) begin
      case ($urandom_range(0, 19))
        0:       w_word = 10'd0;
        1:       w_word = 10'd1;
        2:       w_word = SIZE_W'($urandom_range(MAX_W, 1023));
        default: w_word = SIZE_W'($urandom_range(2, 12));
      endcase
      w_eff = tracker.clip_size(w_word, MAX_W);
      if (w_eff > 16) begin
        h_word = SIZE_W'($urandom_range(0, 2));
      end else begin
        case ($urandom_range(0, 19))
          0:       h_word = 10'd0;
          1:       h_word = 10'd1;
          2:       h_word = SIZE_W'($urandom_range(MAX_H, 1023));
          default: h_word = SIZE_W'($urandom_range(2, 10));
        endcase
      end
      h_eff    = tracker.clip_size(h_word, MAX_H);
      thr_word = CFG_DATA_W'($urandom_range(0, 1023));
      case ($urandom_range(0, 6))
        0: thr_word[THR_W-1:0] = '0;
        1: thr_word[THR_W-1:0] = '1;
        default: ;
      endcase
      configure(w_word, h_word, thr_word);
      // some settings run flat out on one side or both
      feed_paced = ($urandom_range(0, 3) != 0);
      sink_paced = ($urandom_range(0, 3) != 0);
      if (phase_no == 3) hold_off_cycles = 60;

      frames   = $urandom_range(1, 3);
      prev_cut = 1'b0;
      for (int f = 0; f < frames; f++) begin
        full = w_eff * h_eff;
        len  = full;
        cut  = 1'b0;
        if (full > CUT_LEN || $urandom_range(0, 9) == 0) begin
          len = $urandom_range(1, (full > CUT_LEN) ? CUT_LEN : full);
          cut = 1'b1;
        end
        fs_first = (f == 0) || prev_cut || ($urandom_range(0, 4) != 0);
        for (int unsigned k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0: pix = 8'h00;
            1: pix = 8'hFF;
            2, 3: begin
              // land right at or just past the threshold from the last pixel
              delta = int'(thr_word[THR_W-1:0]) + int'($urandom_range(0, 1));
              v = $urandom_range(0, 1) ? int'(last_pix) + delta : int'(last_pix) - delta;
              if (v < 0 || v > 255) v = 2 * int'(last_pix) - v;
              if (v < 0 || v > 255) v = $urandom_range(0, 255);
              pix = PIX_W'(v);
            end
            default: pix = PIX_W'($urandom_range(0, 255));
          endcase
          send_pixel(pix, (k == 0) && fs_first);
          last_pix = pix;
        end
        prev_cut = cut;
      end
      phase_no++;
    end

    // ---- wide run: two rows at the width cap, threshold zero ----
    // checkerboard of low and high greys makes every pixel count; the last
    // column is reached, and a few beats run on past the frame end with no
    // frame_start
    configure(10'd1023, 10'd2, 10'd0);
    feed_paced      = 1'b0;
    sink_paced      = 1'b0;
    hold_off_cycles = 200;   // sender keeps pushing, block must back up
    for (int unsigned k = 0; k < 2 * MAX_W + 8; k++) begin
      r   = (k / MAX_W) % 2;
      c   = k % MAX_W;
      pix = ((r + c) % 2) ? PIX_W'($urandom_range(128, 255)) : PIX_W'($urandom_range(0, 127));
      send_pixel(pix, k == 0);
    end

    // ---- drain ----
    @(negedge clk);
    in_valid   = 1'b0;
    drain_wait = 0;
    while (tracker.pending() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d predicted results never came", tracker.pending()));

    $display("tb_top: %0d pixel beats under %0d register settings, %0d results checked",
             beats_sent, settings_used, tracker.results_seen);
    $display("tb_top: %0d frames closed, rows up to the width cap, output held off under load",
             tracker.frames_done);
    if (tracker.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #(64'd3_000_000 * CLK_PERIOD);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
